// ===== design/ucn_pkg.sv =====
`default_nettype none
package ucn_pkg;

  // Emitted-character counter width
  localparam int unsigned COUNT_WIDTH = 16;
  // Compare width for counter against the 16-bit limit register
  localparam int unsigned CMP_WIDTH   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  // Bytes kept back while a multi-byte sequence is gathered
  localparam int unsigned HOLD_DEPTH  = 5;
  // Entries in the front/back queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] MAX_CHARS_RESET = 16'hffff;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // What the back end does with one queued beat
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,  // terminator only
    OP_EMIT  = 2'd1,  // send the byte as it is
    OP_HOLD  = 2'd2,  // keep the byte for a later flush
    OP_FLUSH = 2'd3   // send the kept bytes, then this byte
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       term;
  } entry_t;

  // Queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Sequence length from a lead byte, zero for an invalid lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if ((b & 8'h80) == 8'h00)      len = 3'd1;
    else if ((b & 8'he0) == 8'hc0) len = 3'd2;
    else if ((b & 8'hf0) == 8'he0) len = 3'd3;
    else if ((b & 8'hf8) == 8'hf0) len = 3'd4;
    else if ((b & 8'hfc) == 8'hf8) len = 3'd5;
    else if ((b & 8'hfe) == 8'hfc) len = 3'd6;
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== design/ucn_if.sv =====
`default_nettype none
// Input byte channel
interface ucn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

// Output byte channel
interface ucn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_terminator;

  modport source (output valid, output out_byte, output is_terminator, input ready);
  modport sink   (input valid, input out_byte, input is_terminator, output ready);
endinterface
`default_nettype wire

// ===== design/ucn_front.sv =====
`default_nettype none
module ucn_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ucn_in_if.sink                 in_i,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire ucn_pkg::qstat_t   qstat_i,
  output      logic              push_o,
  output      ucn_pkg::entry_t   entry_o
);
  import ucn_pkg::*;

  logic [15:0]            max_q;
  logic                   halted_q, halted_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   sb_q, sb_d;
  logic [2:0]             held_q, held_d;
  logic [2:0]             seq_q, seq_d;
  logic                   accept;
  logic                   limit;
  logic                   bump;
  logic [2:0]             len;
  logic [3:0]             held_next;
  op_e                    op;

  assign in_i.ready = !qstat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign len        = lead_length(in_i.in_byte);
  assign held_next  = {1'b0, held_q} + 4'd1;
  assign limit      = (CMP_WIDTH'(count_q) >= CMP_WIDTH'(max_q)) || (&count_q);

  // Classify the beat and work out the per-string state
  always_comb begin
    op       = OP_NONE;
    bump     = 1'b0;
    halted_d = halted_q;
    sb_d     = sb_q;
    held_d   = held_q;
    seq_d    = seq_q;
    if (!halted_q) begin
      if (seq_q != 3'd0) begin
        if (held_next >= {1'b0, seq_q}) begin
          op     = OP_FLUSH;
          bump   = 1'b1;
          sb_d   = 1'b0;
          held_d = 3'd0;
          seq_d  = 3'd0;
        end else begin
          op     = OP_HOLD;
          held_d = held_next[2:0];
        end
      end else if (limit) begin
        halted_d = 1'b1;
      end else if (in_i.in_byte == CHAR_CR || in_i.in_byte == CHAR_LF ||
                   in_i.in_byte == CHAR_TAB) begin
        op = OP_NONE;
      end else if (in_i.in_byte == CHAR_SPACE) begin
        if (!sb_q) begin
          op   = OP_EMIT;
          bump = 1'b1;
          sb_d = 1'b1;
        end
      end else if (len == 3'd0) begin
        halted_d = 1'b1;
      end else if (len == 3'd1) begin
        op   = OP_EMIT;
        bump = 1'b1;
        sb_d = 1'b0;
      end else begin
        op     = OP_HOLD;
        held_d = 3'd1;
        seq_d  = len;
      end
    end
    // saturating count
    count_d = (bump && !(&count_q)) ? count_q + COUNT_WIDTH'(1) : count_q;
    // end of string: back to the initial state
    if (in_i.is_final) begin
      halted_d = 1'b0;
      count_d  = '0;
      sb_d     = 1'b1;
      held_d   = 3'd0;
      seq_d    = 3'd0;
    end
  end

  assign push_o        = accept && ((op != OP_NONE) || in_i.is_final);
  assign entry_o.op    = op;
  assign entry_o.data  = in_i.in_byte;
  assign entry_o.term  = in_i.is_final;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_CHARS_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // Per-string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      count_q  <= '0;
      sb_q     <= 1'b1;
      held_q   <= 3'd0;
      seq_q    <= 3'd0;
    end else if (accept) begin
      halted_q <= halted_d;
      count_q  <= count_d;
      sb_q     <= sb_d;
      held_q   <= held_d;
      seq_q    <= seq_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/ucn_queue.sv =====
`default_nettype none
module ucn_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ucn_pkg::entry_t   entry_i,
  input  wire logic              pop_i,
  output      ucn_pkg::entry_t   entry_o,
  output      ucn_pkg::qstat_t   qstat_o
);
  import ucn_pkg::*;

  entry_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_q, rd_q;
  logic [QPTR_WIDTH:0]   fill_q;

  assign qstat_o.full  = (fill_q == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
  assign qstat_o.empty = (fill_q == '0);
  assign entry_o       = mem_q[rd_q];

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_WIDTH'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_WIDTH'(1);
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + (QPTR_WIDTH+1)'(1);
        2'b01:   fill_q <= fill_q - (QPTR_WIDTH+1)'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/ucn_back.sv =====
`default_nettype none
module ucn_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ucn_pkg::entry_t   entry_i,
  input  wire ucn_pkg::qstat_t   qstat_i,
  output      logic              pop_o,
  ucn_out_if.source              out_o
);
  import ucn_pkg::*;

  logic [7:0] buf_q [HOLD_DEPTH];
  logic [2:0] cnt_q;
  logic [2:0] step_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_term_q;
  logic       head_valid;
  logic       out_free;
  logic [2:0] nbytes;
  logic [2:0] total;
  logic       last_step;
  logic       load;
  logic [7:0] next_byte;
  logic       next_term;

  assign head_valid = !qstat_i.empty;
  assign out_free   = !out_valid_q || out_o.ready;

  // Number of data bytes this beat produces, terminator not counted
  always_comb begin
    unique case (entry_i.op)
      OP_EMIT:  nbytes = 3'd1;
      OP_FLUSH: nbytes = cnt_q + 3'd1;
      default:  nbytes = 3'd0;
    endcase
  end
  assign total     = nbytes + {2'b00, entry_i.term};
  assign last_step = (step_q + 3'd1 == total);
  assign load      = head_valid && (total != 3'd0) && out_free;
  assign pop_o     = head_valid && ((total == 3'd0) || (out_free && last_step));

  // Pick the result for the current step: kept bytes, this byte, terminator
  always_comb begin
    next_term = 1'b0;
    next_byte = entry_i.data;
    if (step_q >= nbytes) begin
      next_term = 1'b1;
      next_byte = 8'h00;
    end else if (entry_i.op == OP_FLUSH && step_q < cnt_q) begin
      next_byte = buf_q[step_q];
    end
  end

  // Kept-byte storage
  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.op == OP_HOLD && !entry_i.term) begin
      buf_q[cnt_q] <= entry_i.data;
    end
  end

  // Step counter and kept-byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 3'd0;
      step_q <= 3'd0;
    end else begin
      if (pop_o) begin
        step_q <= 3'd0;
        if (entry_i.term || entry_i.op == OP_FLUSH) begin
          cnt_q <= 3'd0;
        end else if (entry_i.op == OP_HOLD) begin
          cnt_q <= cnt_q + 3'd1;
        end
      end else if (load) begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= next_byte;
      out_term_q <= next_term;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.is_terminator = out_term_q;

  // Kept bytes never exceed the buffer
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(HOLD_DEPTH)) else $error("kept-byte count overflow");

  // A flush always follows a held lead byte
  a_flush_has_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid && entry_i.op == OP_FLUSH) |-> (cnt_q != 3'd0))
    else $error("flush with no held lead byte");

  // A hold never lands on a full buffer
  a_hold_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid && entry_i.op == OP_HOLD && !entry_i.term) |-> (cnt_q < 3'(HOLD_DEPTH)))
    else $error("hold into full buffer");

endmodule
`default_nettype wire

// ===== design/utf8_whitespace_normalizing_copy.sv =====
`default_nettype none
// Whitespace-normalizing UTF-8 copy. Takes one input beat per cycle as long as
// the four-entry queue between the classifier and the emitter has room; the
// classifier decides each byte in the cycle it is accepted. The emitter sends
// one output beat per cycle while the receiver is ready: a one-byte character
// or space is one beat, an N-byte sequence leaves as N beats once its last
// byte arrives, and the end of a string adds one terminator beat. Input stalls
// only when the queue is full, when bursts (sequence flushes, terminators)
// or receiver stalls back it up. The limit register may be written only
// while the block is idle.
module utf8_whitespace_normalizing_copy (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ucn_in_if.sink           in_i,
  ucn_out_if.source        out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);
  import ucn_pkg::*;

  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head_entry;
  qstat_t qstat;

  ucn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  ucn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .qstat_o (qstat)
  );

  ucn_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

// ===== tb/utf8_whitespace_normalizing_copy_tb.sv =====
`default_nettype none
module utf8_whitespace_normalizing_copy_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucn_pkg::*;

  localparam int unsigned RUN_LIMIT     = 100000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CHUNK_ITEMS   = 22;
  localparam logic [15:0] LIMIT_MIN     = 16'd1;
  localparam logic [15:0] LIMIT_MAX     = 16'hffff;
  localparam longint unsigned COUNT_CEIL = (64'd1 << COUNT_WIDTH) - 1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_terminator;
  } text_beat_t;

  typedef logic [7:0] byte_q_t[$];

  // Predicts the normalized output stream and checks each output beat
  class normalized_copy_scoreboard;
    logic [15:0]     max_chars;
    bit              halted;
    longint unsigned emitted;
    bit              space_blocked;
    logic [7:0]      held [HOLD_DEPTH];
    int unsigned     held_count;
    int unsigned     seq_length;
    text_beat_t      expected_beats[$];
    int unsigned     errors;

    function new();
      max_chars = MAX_CHARS_RESET;
      errors    = 0;
      start_string();
    endfunction

    function void start_string();
      halted        = 1'b0;
      emitted       = 0;
      space_blocked = 1'b1;
      held_count    = 0;
      seq_length    = 0;
    endfunction

    // Sequence length from the top bits of a lead byte, 0 if invalid
    function int unsigned seq_length_of(logic [7:0] b);
      casez (b)
        8'b0???????: return 1;
        8'b110?????: return 2;
        8'b1110????: return 3;
        8'b11110???: return 4;
        8'b111110??: return 5;
        8'b1111110?: return 6;
        default:     return 0;
      endcase
    endfunction

    function bit limit_hit();
      return (emitted >= max_chars) || (emitted >= COUNT_CEIL);
    endfunction

    function void count_char();
      if (emitted < COUNT_CEIL) emitted++;
    endfunction

    function void emit(logic [7:0] b, logic term);
      text_beat_t beat;
      beat.out_byte      = b;
      beat.is_terminator = term;
      expected_beats.push_back(beat);
    endfunction

    function void note_input_byte(logic [7:0] b, logic fin);
      int unsigned lead_len;
      if (!halted) begin
        if (seq_length != 0) begin
          // inside a sequence every byte is taken as it stands
          if (held_count + 1 >= seq_length) begin
            for (int i = 0; i < held_count; i++) emit(held[i], 1'b0);
            emit(b, 1'b0);
            count_char();
            space_blocked = 1'b0;
            held_count    = 0;
            seq_length    = 0;
          end else if (held_count < HOLD_DEPTH) begin
            held[held_count] = b;
            held_count++;
          end
        end else if (limit_hit()) begin
          halted = 1'b1;
        end else if (b == CHAR_CR || b == CHAR_LF || b == CHAR_TAB) begin
          // control bytes vanish
        end else if (b == CHAR_SPACE) begin
          if (!space_blocked) begin
            emit(b, 1'b0);
            count_char();
            space_blocked = 1'b1;
          end
        end else begin
          lead_len = seq_length_of(b);
          if (lead_len == 0) begin
            halted = 1'b1;
          end else if (lead_len == 1) begin
            emit(b, 1'b0);
            count_char();
            space_blocked = 1'b0;
          end else begin
            held[0]    = b;
            held_count = 1;
            seq_length = lead_len;
          end
        end
      end
      // end of string: terminator, then fresh per-string state
      if (fin) begin
        emit(8'h00, 1'b1);
        start_string();
      end
    endfunction

    function void check_output_beat(logic [7:0] b, logic term);
      text_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected output beat: out_byte=%h is_terminator=%b", b, term);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (b !== want.out_byte) begin
        $error("out_byte mismatch: expected %h, actual %h", want.out_byte, b);
        errors++;
      end
      if (term !== want.is_terminator) begin
        $error("is_terminator mismatch: expected %b, actual %b", want.is_terminator, term);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count = 0;
  byte_q_t     directed_text;

  normalized_copy_scoreboard sb = new();

  ucn_in_if  byte_in ();
  ucn_out_if byte_out ();

  utf8_whitespace_normalizing_copy DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (byte_in),
    .out_o       (byte_out),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls at random
  always @(posedge clk_i) begin
    byte_out.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Output beat monitor
  always @(posedge clk_i) begin
    if (rst_ni && byte_out.valid && byte_out.ready) begin
      sb.check_output_beat(byte_out.out_byte, byte_out.is_terminator);
    end
  end

  // One input beat, with random idle cycles ahead of it
  task automatic send_beat(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_in.valid    <= 1'b1;
    byte_in.in_byte  <= b;
    byte_in.is_final <= fin;
    do @(posedge clk_i); while (!byte_in.ready);
    sb.note_input_byte(b, fin);
  endtask

  // Sender holds off until every predicted beat has come out
  task automatic hold_until_drained();
    byte_in.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_beats.size() != 0);
  endtask

  task automatic write_max_chars(input logic [15:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    sb.max_chars = value;
  endtask

  task automatic send_text(input byte_q_t text);
    foreach (text[i]) begin
      if ($urandom_range(49) == 0) hold_until_drained();
      send_beat(text[i], i == text.size() - 1);
    end
  endtask

  function automatic logic [7:0] lead_byte(input int unsigned len);
    case (len)
      2:       return 8'hc0 + 8'($urandom_range(31));
      3:       return 8'he0 + 8'($urandom_range(15));
      4:       return 8'hf0 + 8'($urandom_range(7));
      5:       return 8'hf8 + 8'($urandom_range(3));
      6:       return 8'hfc + 8'($urandom_range(1));
      default: return 8'($urandom_range(8'h7f));
    endcase
  endfunction

  // Mostly proper continuation bytes, sometimes anything
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(99) < 85) return 8'h80 + 8'($urandom_range(63));
    return 8'($urandom_range(255));
  endfunction

  // Random string built from tokens: text, spaces, controls, sequences, stray bytes
  function automatic void build_random_text(output byte_q_t text);
    int unsigned tokens;
    int unsigned kind;
    int unsigned len;
    text   = {};
    tokens = $urandom_range(12, 1);
    for (int t = 0; t < tokens; t++) begin
      kind = $urandom_range(99);
      if (kind < 38) begin
        text.push_back(8'h21 + 8'($urandom_range(93)));
      end else if (kind < 52) begin
        text.push_back(CHAR_SPACE);
      end else if (kind < 60) begin
        case ($urandom_range(2))
          0:       text.push_back(CHAR_CR);
          1:       text.push_back(CHAR_LF);
          default: text.push_back(CHAR_TAB);
        endcase
      end else if (kind < 64) begin
        text.push_back(8'($urandom_range(8'h7f)));
      end else if (kind < 95) begin
        len = $urandom_range(6, 2);
        text.push_back(lead_byte(len));
        repeat (len - 1) text.push_back(cont_byte());
      end else if (kind < 97) begin
        if ($urandom_range(1) == 0) text.push_back(8'h80 + 8'($urandom_range(63)));
        else text.push_back(8'hfe + 8'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(4, 2)) text.push_back(CHAR_SPACE);
      end
    end
    // now and then the string ends inside a sequence
    if ($urandom_range(7) == 0) begin
      len = $urandom_range(6, 2);
      text.push_back(lead_byte(len));
      repeat ($urandom_range(len - 2)) text.push_back(cont_byte());
    end
  endfunction

  // Main sequence
  initial begin
    byte_q_t     text;
    int unsigned chunk_items;
    byte_in.valid    = 1'b0;
    byte_in.in_byte  = 8'h00;
    byte_in.is_final = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 16'h0000;
    send_idle_pct    = 23;
    recv_idle_pct    = 51;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: leading, repeated spaces, controls, zero byte
    write_max_chars(LIMIT_MAX);
    directed_text = '{CHAR_SPACE, CHAR_TAB, 8'h41, CHAR_SPACE, CHAR_SPACE, CHAR_CR,
                      8'h00, CHAR_LF, 8'h7f};
    send_text(directed_text);
    // two-byte, six-byte holding controls and bad bytes, then invalid lead halts
    directed_text = '{8'hc3, 8'ha9, 8'hfc, CHAR_CR, CHAR_SPACE, 8'hff, CHAR_LF, 8'h80,
                      8'hfe, 8'h41, 8'h42};
    send_text(directed_text);
    // sequence cut short by the end of the string
    directed_text = '{8'he2, 8'h82};
    send_text(directed_text);
    // limit of one: halts on the control byte
    write_max_chars(LIMIT_MIN);
    directed_text = '{CHAR_SPACE, 8'h41, CHAR_CR, 8'h42};
    send_text(directed_text);

    // Random strings across idle modes and limit settings
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 3; s++) begin
        case (s)
          0:       write_max_chars(LIMIT_MAX);
          1:       write_max_chars(LIMIT_MIN);
          default: write_max_chars(16'($urandom_range(12, 2)));
        endcase
        chunk_items = 0;
        while (chunk_items < CHUNK_ITEMS) begin
          build_random_text(text);
          send_text(text);
          chunk_items += text.size();
        end
      end
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
